// ----- design/rgbh_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbh_pkg
// Shared types and constants for the RGB channel histogram: item layouts,
// item kind codes and default sizes.
// ----------------------------------------------------------------------------
package rgbh_pkg;

    localparam int BIN_COUNT_DEF   = 256;
    localparam int COUNT_WIDTH_DEF = 25;
    localparam int LANES           = 3;

    localparam int BYTE_W      = 8;
    localparam int OUT_COUNT_W = 25;

    // item kind codes
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] bin_select;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]      bin_number;
        logic [OUT_COUNT_W-1:0] red_count;
        logic [OUT_COUNT_W-1:0] green_count;
        logic [OUT_COUNT_W-1:0] blue_count;
    } rsp_t;

endpackage

// ----- design/rgb_channel_histogram.sv -----
// ----------------------------------------------------------------------------
// rgb_channel_histogram
// Three-channel pixel histogram held in one synchronous memory per channel,
// updated by a read-modify-write pipeline with write-back forwarding.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  cmd     | in        | cmd_valid / cmd_stall | kind, red, green, blue, bin_select
//  rsp     | out       | rsp_valid / rsp_stall | bin_number, red/green/blue_count
//
//  Pixel and read items are taken one per cycle while cmd_stall is low: the
//  memory read happens at the accepting edge, the increment and write-back at the following edge.
//  A read item's result is loaded into the output register when the item
//  leaves the update stage.
//  A clear item stalls cmd while it drains the pipeline stage and then while
//  one bin of each memory is zeroed per cycle.
//  After reset the same clearing pass runs over every bin before the
//  first item is taken.
//  A result held by rsp_stall holds the next read item in the update stage;
//  cmd also stalls while that stage cannot advance.
//
module rgb_channel_histogram #(
    parameter int BIN_COUNT   = rgbh_pkg::BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = rgbh_pkg::COUNT_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  rgbh_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rgbh_pkg::rsp_t rsp
);
    import rgbh_pkg::*;

    localparam int AW      = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int RANGE_W = 13;

    typedef logic [AW-1:0]          addr_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t COUNT_MAX = '1;
    localparam addr_t  LAST_BIN  = AW'(BIN_COUNT - 1);

    // Handshake and pipeline control
    logic        cmd_accept;
    logic        s1_valid_reg;
    logic [1:0]  s1_kind_reg;
    logic [7:0]  s1_sel_reg;
    logic        s1_hold;
    logic        s1_go;
    logic        clear_busy_reg;
    addr_t       clear_pos_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;

    // Per-channel views
    logic [7:0]  lane_byte [LANES];
    count_t      lane_cur  [LANES];
    logic        lane_hit  [LANES];

    assign cmd_accept = cmd_valid && !cmd_stall;

    // A read item cannot leave the update stage while the previous result waits.
    assign s1_hold = s1_valid_reg && (s1_kind_reg == KIND_READ)
                     && rsp_valid_reg && rsp_stall;
    assign s1_go   = s1_valid_reg && !s1_hold;

    // Hold off new items during a clear pass, while a clear item drains,
    // and while the update stage is held.
    assign cmd_stall = clear_busy_reg
                       || (s1_valid_reg && (s1_kind_reg == KIND_CLEAR))
                       || s1_hold;

    assign lane_byte[0] = cmd.red;
    assign lane_byte[1] = cmd.green;
    assign lane_byte[2] = cmd.blue;

    // One memory, address register and write-back register per channel
    for (genvar c = 0; c < LANES; c++) begin : g_lane
        count_t     mem [BIN_COUNT];
        count_t     rd_data_reg;
        addr_t      s1_addr_reg;
        logic       s1_hit_reg;
        logic       wb_valid_reg;
        addr_t      wb_addr_reg;
        count_t     wb_data_reg;
        logic [7:0] acc_byte;
        addr_t      acc_addr;
        logic       acc_hit;
        count_t     cur;
        count_t     bumped;
        logic       wr_en;
        addr_t      wr_addr;
        count_t     wr_data;

        // Read items address the selected bin, pixel items the channel byte.
        assign acc_byte = (cmd.kind == KIND_READ) ? cmd.bin_select : lane_byte[c];
        assign acc_addr = AW'(acc_byte);
        assign acc_hit  = (RANGE_W'(acc_byte) < RANGE_W'(BIN_COUNT));

        // Forward the most recent write to this channel when it hits the same bin.
        assign cur    = (wb_valid_reg && (wb_addr_reg == s1_addr_reg))
                        ? wb_data_reg : rd_data_reg;
        assign bumped = (cur == COUNT_MAX) ? cur : cur + count_t'(1);

        assign wr_en   = clear_busy_reg
                         || (s1_go && (s1_kind_reg == KIND_PIXEL) && s1_hit_reg);
        assign wr_addr = clear_busy_reg ? clear_pos_reg : s1_addr_reg;
        assign wr_data = clear_busy_reg ? '0 : bumped;

        assign lane_cur[c] = cur;
        assign lane_hit[c] = s1_hit_reg;

        always_ff @(posedge clk) begin
            if (wr_en) begin
                mem[wr_addr] <= wr_data;
            end
            if (cmd_accept) begin
                rd_data_reg <= mem[acc_addr];
            end
        end

        always_ff @(posedge clk) begin
            if (cmd_accept) begin
                s1_addr_reg <= acc_addr;
                s1_hit_reg  <= acc_hit;
            end
            if (wr_en) begin
                wb_addr_reg <= wr_addr;
                wb_data_reg <= wr_data;
            end
        end

        // Drop forwarding during a clear pass; the memory then holds zeros.
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                wb_valid_reg <= 1'b0;
            end
            else if (clear_busy_reg) begin
                wb_valid_reg <= 1'b0;
            end
            else if (wr_en) begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // Update stage, clear sweep and result register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg   <= 1'b0;
            clear_busy_reg <= 1'b1;
            clear_pos_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else begin
            // advance the update stage
            if (cmd_accept) begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end

            // sweep every bin once, then release the input
            if (clear_busy_reg) begin
                if (clear_pos_reg == LAST_BIN) begin
                    clear_busy_reg <= 1'b0;
                    clear_pos_reg  <= '0;
                end
                else begin
                    clear_pos_reg <= clear_pos_reg + addr_t'(1);
                end
            end
            else if (s1_go && (s1_kind_reg == KIND_CLEAR)) begin
                clear_busy_reg <= 1'b1;
                clear_pos_reg  <= '0;
            end

            // load a read result, drop it once taken
            if (s1_go && (s1_kind_reg == KIND_READ)) begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd_accept) begin
            s1_kind_reg <= cmd.kind;
            s1_sel_reg  <= cmd.bin_select;
        end
        if (s1_go && (s1_kind_reg == KIND_READ)) begin
            rsp_reg.bin_number  <= s1_sel_reg;
            rsp_reg.red_count   <= lane_hit[0] ? OUT_COUNT_W'(lane_cur[0]) : '0;
            rsp_reg.green_count <= lane_hit[1] ? OUT_COUNT_W'(lane_cur[1]) : '0;
            rsp_reg.blue_count  <= lane_hit[2] ? OUT_COUNT_W'(lane_cur[2]) : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- design/rgbh_checker.sv -----
// ----------------------------------------------------------------------------
// rgbh_checker
// Port-level checks for the RGB channel histogram, bound to the top level.
// ----------------------------------------------------------------------------
module rgbh_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_stall,
    input rgbh_pkg::cmd_t cmd,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input rgbh_pkg::rsp_t rsp
);
    import rgbh_pkg::*;

    logic cmd_take;

    assign cmd_take = cmd_valid && !cmd_stall;

    // A held result stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // A clear item blocks the next cycle's input.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && (cmd.kind == KIND_CLEAR) |=> cmd_stall)
        else $error("input taken right after a clear item");

    // A read into an idle pipeline returns its bin through the update stage and the result register.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd_take) && cmd_take && (cmd.kind == KIND_READ) && !rsp_valid
        |=> ##1 rsp_valid && (rsp.bin_number == $past(cmd.bin_select, 2)))
        else $error("read result missing or wrong bin");

    // Pixel items never produce a result.
    a_pixel_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd_take) && cmd_take && (cmd.kind == KIND_PIXEL) && !rsp_valid
        |=> ##1 !rsp_valid)
        else $error("result produced by a pixel item");

endmodule

bind rgb_channel_histogram rgbh_checker u_rgbh_checker (.*);
